// ----- rtl/core/rdc_pkg.sv -----
// ----------------------------------------------------------------------------
// Raycaster package
// Shared constants, codes and control types of the grid raycaster core.
// ----------------------------------------------------------------------------
`default_nettype none

package rdc_pkg;

   // Map and number formats
   localparam int MAP_DIM    = 64;
   localparam int CELL_W     = $clog2(MAP_DIM);
   localparam int ADDR_W     = 2 * CELL_W;
   localparam int FRAC_BITS  = 16;
   localparam int DIR_FRAC   = 14;
   localparam int POS_W      = 22;
   localparam int DIR_W      = 16;
   localparam int MAG_W      = 16;
   localparam int NEXT_W     = 24;
   localparam int PROD_W     = NEXT_W + MAG_W;
   localparam int DIV_W      = PROD_W;
   localparam int DCNT_W     = $clog2(DIV_W);
   localparam int COORD_W    = 8;
   localparam int CODE_W     = 8;
   localparam int SIZE_W     = 7;
   localparam int DIST_W     = 23;
   localparam int TEX_W      = 16;
   localparam int SIDE_W     = 2;
   localparam int STEP_MAX   = 2 * MAP_DIM + 4;
   localparam int GUARD_W    = $clog2(STEP_MAX + 1);

   localparam logic [CODE_W-1:0] EMPTY_CODE = 8'd32;
   localparam logic [DIST_W-1:0] DIST_MAX   = 23'h7FFFFF;
   localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAP_DIM);
   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);
   localparam logic [NEXT_W-1:0] UNIT       = NEXT_W'(1) << FRAC_BITS;

   // Commands of the request word
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_CAST  = 1'b1;

   // Register indexes
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HEIGHT = 2'd1;

   // Side codes
   localparam logic [SIDE_W-1:0] SIDE_POS_X = 2'd0;
   localparam logic [SIDE_W-1:0] SIDE_POS_Y = 2'd1;
   localparam logic [SIDE_W-1:0] SIDE_NEG_X = 2'd2;
   localparam logic [SIDE_W-1:0] SIDE_NEG_Y = 2'd3;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic mem_wr;
      logic load;
      logic mul;
      logic step;
      logic rd;
      logic chk;
      logic setup;
      logic div_run;
      logic tmul;
      logic out_load;
   } dp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic stop;
      logic a_zero;
      logic div_done;
   } dp_stat_type;

endpackage

`default_nettype wire

// ----- rtl/core/rdc_if.sv -----
// ----------------------------------------------------------------------------
// Raycaster channel interfaces
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rdc_req_if
   import rdc_pkg::*;
   ;
   logic                     valid;
   logic                     ready;
   logic                     cmd;
   logic [CELL_W-1:0]        cell_x;
   logic [CELL_W-1:0]        cell_y;
   logic [CODE_W-1:0]        cell_code;
   logic [POS_W-1:0]         player_x;
   logic [POS_W-1:0]         player_y;
   logic signed [DIR_W-1:0]  dir_x;
   logic signed [DIR_W-1:0]  dir_y;

   modport source (output valid, cmd, cell_x, cell_y, cell_code, player_x, player_y,
                   dir_x, dir_y, input ready);
   modport sink   (input valid, cmd, cell_x, cell_y, cell_code, player_x, player_y,
                   dir_x, dir_y, output ready);
endinterface

interface rdc_rsp_if
   import rdc_pkg::*;
   ;
   logic                       valid;
   logic                       ready;
   logic                       out_of_bounds;
   logic [CODE_W-1:0]          hit_code;
   logic [SIDE_W-1:0]          side;
   logic [DIST_W-1:0]          distance;
   logic [TEX_W-1:0]           wall_frac;
   logic signed [COORD_W-1:0]  hit_x;
   logic signed [COORD_W-1:0]  hit_y;

   modport source (output valid, out_of_bounds, hit_code, side, distance, wall_frac,
                   hit_x, hit_y, input ready);
   modport sink   (input valid, out_of_bounds, hit_code, side, distance, wall_frac,
                   hit_x, hit_y, output ready);
endinterface

interface rdc_csr_if
   import rdc_pkg::*;
   ;
   logic                   valid;
   logic                   ready;
   logic [CSR_IDX_W-1:0]   index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/rdc_ctrl.sv -----
// ----------------------------------------------------------------------------
// Raycaster controller
// Sequences map writes, DDA steps, the two divisions and the result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_ctrl
   import rdc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_cmd,
   output logic             req_ready,
   input  wire logic        rsp_ready,
   output logic             rsp_valid,
   input  wire dp_stat_type stat,
   output dp_cmd_type       cmd
);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_MUL   = 10'b0000000010,
      S_STEP  = 10'b0000000100,
      S_READ  = 10'b0000001000,
      S_CHECK = 10'b0000010000,
      S_SETUP = 10'b0000100000,
      S_DIVD  = 10'b0001000000,
      S_TMUL  = 10'b0010000000,
      S_DIVT  = 10'b0100000000,
      S_DONE  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;
   assign slot_free = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_CAST) begin
                  cmd.load = 1'b1;
                  state_in = S_MUL;
               end else begin
                  cmd.mem_wr = 1'b1;
               end
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_STEP;
         end
         S_STEP: begin
            cmd.step = 1'b1;
            state_in = S_READ;
         end
         S_READ: begin
            cmd.rd   = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.chk  = 1'b1;
            state_in = stat.stop ? S_SETUP : S_MUL;
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = stat.a_zero ? S_DONE : S_DIVD;
         end
         S_DIVD: begin
            cmd.div_run = 1'b1;
            if (stat.div_done) begin
               state_in = S_TMUL;
            end
         end
         S_TMUL: begin
            cmd.tmul = 1'b1;
            state_in = S_DIVT;
         end
         S_DIVT: begin
            cmd.div_run = 1'b1;
            if (stat.div_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/rdc_dp.sv -----
// ----------------------------------------------------------------------------
// Raycaster datapath
// Map memory, size registers, DDA step unit, shared divider and result word.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_dp
   import rdc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_valid,
   input  wire logic [CSR_IDX_W-1:0]     csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_data,
   input  wire logic [CELL_W-1:0]        cell_x,
   input  wire logic [CELL_W-1:0]        cell_y,
   input  wire logic [CODE_W-1:0]        cell_code,
   input  wire logic [POS_W-1:0]         player_x,
   input  wire logic [POS_W-1:0]         player_y,
   input  wire logic signed [DIR_W-1:0]  dir_x,
   input  wire logic signed [DIR_W-1:0]  dir_y,
   input  wire dp_cmd_type               cmd,
   output dp_stat_type                   stat,
   output logic                          out_of_bounds,
   output logic [CODE_W-1:0]             hit_code,
   output logic [SIDE_W-1:0]             side,
   output logic [DIST_W-1:0]             distance,
   output logic [TEX_W-1:0]              wall_frac,
   output logic signed [COORD_W-1:0]     hit_x,
   output logic signed [COORD_W-1:0]     hit_y
);

   logic [CODE_W-1:0]  mem [MAP_DIM*MAP_DIM];

   logic [SIZE_W-1:0]  width_ff, height_ff;
   logic [SIZE_W-1:0]  w_use, h_use;

   logic [POS_W-1:0]   px_ff, py_ff;
   logic               dx_neg_ff, dy_neg_ff;
   logic [MAG_W-1:0]   ax_ff, ay_ff;
   logic [COORD_W-1:0] cx_ff, cy_ff, cx_in, cy_in;
   logic [NEXT_W-1:0]  nx_ff, ny_ff, n_ff;
   logic [PROD_W-1:0]  prod_a_ff, prod_b_ff;
   logic               ori_ff;
   logic               oob_step_ff;
   logic [GUARD_W-1:0] guard_ff;
   logic [CODE_W-1:0]  rd_data_ff;
   logic               oob_ff;
   logic [CODE_W-1:0]  code_ff;
   logic               x_first;

   logic [DIV_W-1:0]   dq_ff;
   logic [MAG_W-1:0]   rem_ff;
   logic [DCNT_W-1:0]  dcnt_ff;
   logic [DIST_W-1:0]  dist_ff;
   logic [MAG_W:0]     trial;
   logic               ge;
   logic [MAG_W-1:0]   a_sel, t_sel;
   logic [TEX_W-1:0]   base_lo, q_lo, off;
   logic [MAG_W-1:0]   abs_dx, abs_dy;

   // Size registers, clamped to the stored map
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SIZE_RESET;
         height_ff <= SIZE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MAP_WIDTH:  width_ff  <= csr_data;
            CSR_MAP_HEIGHT: height_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign w_use = (width_ff > SIZE_MAX) ? SIZE_MAX : width_ff;
   assign h_use = (height_ff > SIZE_MAX) ? SIZE_MAX : height_ff;

   // Map memory: write on a map word, registered read of the current cell
   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         mem[{cell_y, cell_x}] <= cell_code;
      end
      if (cmd.rd) begin
         rd_data_ff <= mem[{cy_ff[CELL_W-1:0], cx_ff[CELL_W-1:0]}];
      end
   end

   assign abs_dx = dir_x[DIR_W-1] ? MAG_W'(-dir_x) : MAG_W'(dir_x);
   assign abs_dy = dir_y[DIR_W-1] ? MAG_W'(-dir_y) : MAG_W'(dir_y);

   // Which boundary is nearer: cross products compared exactly
   assign x_first = prod_a_ff < prod_b_ff;

   always_comb begin
      cx_in = cx_ff;
      cy_in = cy_ff;
      if (x_first) begin
         cx_in = dx_neg_ff ? cx_ff - COORD_W'(1) : cx_ff + COORD_W'(1);
      end else begin
         cy_in = dy_neg_ff ? cy_ff - COORD_W'(1) : cy_ff + COORD_W'(1);
      end
   end

   // DDA stepping
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         px_ff     <= player_x;
         py_ff     <= player_y;
         dx_neg_ff <= dir_x[DIR_W-1];
         dy_neg_ff <= dir_y[DIR_W-1];
         ax_ff     <= abs_dx;
         ay_ff     <= abs_dy;
         cx_ff     <= COORD_W'(player_x[POS_W-1:FRAC_BITS]);
         cy_ff     <= COORD_W'(player_y[POS_W-1:FRAC_BITS]);
         nx_ff     <= dir_x[DIR_W-1] ? NEXT_W'(player_x[FRAC_BITS-1:0])
                                     : UNIT - NEXT_W'(player_x[FRAC_BITS-1:0]);
         ny_ff     <= dir_y[DIR_W-1] ? NEXT_W'(player_y[FRAC_BITS-1:0])
                                     : UNIT - NEXT_W'(player_y[FRAC_BITS-1:0]);
         guard_ff  <= '0;
      end
      if (cmd.mul) begin
         prod_a_ff <= nx_ff * ay_ff;
         prod_b_ff <= ny_ff * ax_ff;
      end
      if (cmd.step) begin
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
         guard_ff <= guard_ff + GUARD_W'(1);
         ori_ff   <= ~x_first;
         if (x_first) begin
            n_ff  <= nx_ff;
            nx_ff <= nx_ff + UNIT;
         end else begin
            n_ff  <= ny_ff;
            ny_ff <= ny_ff + UNIT;
         end
         oob_step_ff <= cx_in[COORD_W-1] | cy_in[COORD_W-1]
                      | (cx_in[SIZE_W-1:0] >= w_use) | (cy_in[SIZE_W-1:0] >= h_use);
      end
      if (cmd.chk) begin
         oob_ff  <= oob_step_ff | (rd_data_ff == EMPTY_CODE);
         code_ff <= rd_data_ff;
      end
   end

   assign stat.stop = oob_step_ff | (rd_data_ff != EMPTY_CODE)
                    | (guard_ff == GUARD_W'(STEP_MAX));

   // Divisor and cross factor follow the axis crossed last
   assign a_sel       = ori_ff ? ay_ff : ax_ff;
   assign t_sel       = ori_ff ? ax_ff : ay_ff;
   assign stat.a_zero = (a_sel == '0);

   // Restoring divider, one quotient bit a cycle
   assign trial         = {rem_ff, dq_ff[DIV_W-1]};
   assign ge            = trial >= {1'b0, a_sel};
   assign stat.div_done = (dcnt_ff == DCNT_W'(DIV_W - 1));

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         dq_ff   <= {{(DIV_W-NEXT_W-DIR_FRAC){1'b0}}, n_ff, {DIR_FRAC{1'b0}}};
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end else if (cmd.tmul) begin
         dist_ff <= (dq_ff > DIV_W'(DIST_MAX)) ? DIST_MAX : dq_ff[DIST_W-1:0];
         dq_ff   <= n_ff * t_sel;
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_run) begin
         rem_ff  <= ge ? MAG_W'(trial - {1'b0, a_sel}) : trial[MAG_W-1:0];
         dq_ff   <= {dq_ff[DIV_W-2:0], ge};
         dcnt_ff <= dcnt_ff + DCNT_W'(1);
      end
   end

   // Fraction of the hit point along the wall face, floored
   assign base_lo = ori_ff ? px_ff[TEX_W-1:0] : py_ff[TEX_W-1:0];
   assign q_lo    = dq_ff[TEX_W-1:0];

   always_comb begin
      if ((ori_ff ? dx_neg_ff : dy_neg_ff)) begin
         off = base_lo - q_lo - TEX_W'(rem_ff != '0);
      end else begin
         off = base_lo + q_lo;
      end
   end

   // Result word
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_of_bounds <= oob_ff;
         hit_code      <= oob_ff ? '0 : code_ff;
         if (ori_ff) begin
            side <= dy_neg_ff ? SIDE_NEG_Y : SIDE_POS_Y;
         end else begin
            side <= dx_neg_ff ? SIDE_NEG_X : SIDE_POS_X;
         end
         distance   <= stat.a_zero ? DIST_MAX : dist_ff;
         wall_frac  <= stat.a_zero ? '0 : off;
         hit_x      <= cx_ff;
         hit_y      <= cy_ff;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/grid_dda_raycaster_core.sv -----
// ----------------------------------------------------------------------------
// Grid DDA raycaster core
// Top level: tile map store and ray caster over it.
// ----------------------------------------------------------------------------
// Usage: a request word with cmd = write stores cell_code at (cell_x, cell_y)
// and gives no response. A request word with cmd = cast
// traces one ray from (player_x, player_y) along (dir_x, dir_y) and gives one
// response word: hit code or out-of-bounds flag, side, distance, texture
// offset and final cell. Register writes on the csr channel set the map
// width (index 0) and height (index 1); they are taken at any time, but
// should only be issued while the core is idle.
// A cast runs, from acceptance to response valid, through each DDA step
// (product, step, map read, test), a setup state, two restoring divisions
// with a cross product state between them, and the load of the output
// register; a ray takes at most 132 DDA steps. A ray with a zero component
// on the crossed axis skips the divisions.
// A cast occupies the core until its response sits in the output register;
// the next request word is taken while that response waits. If the receiver
// stalls with a response still held, a finished cast waits in its last state.
// Reset empties the output register and sets both sizes to 64; map contents
// are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_dda_raycaster_core
   import rdc_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   rdc_req_if.sink    req_ch,
   rdc_rsp_if.source  rsp_ch,
   rdc_csr_if.sink    csr_ch
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   assign csr_ch.ready = 1'b1;

   rdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_cmd   (req_ch.cmd),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   rdc_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_ch.valid),
      .csr_index     (csr_ch.index),
      .csr_data      (csr_ch.data),
      .cell_x        (req_ch.cell_x),
      .cell_y        (req_ch.cell_y),
      .cell_code     (req_ch.cell_code),
      .player_x      (req_ch.player_x),
      .player_y      (req_ch.player_y),
      .dir_x         (req_ch.dir_x),
      .dir_y         (req_ch.dir_y),
      .cmd           (cmd),
      .stat          (stat),
      .out_of_bounds (rsp_ch.out_of_bounds),
      .hit_code      (rsp_ch.hit_code),
      .side          (rsp_ch.side),
      .distance      (rsp_ch.distance),
      .wall_frac     (rsp_ch.wall_frac),
      .hit_x         (rsp_ch.hit_x),
      .hit_y         (rsp_ch.hit_y)
   );

endmodule

`default_nettype wire

// ----- rtl/core/rdc_checker.sv -----
// ----------------------------------------------------------------------------
// Raycaster port checker
// Concurrent assertions on the top level ports, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_checker
   import rdc_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire logic                     req_cmd,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic                     rsp_oob,
   input wire logic [CODE_W-1:0]        rsp_code,
   input wire logic signed [COORD_W-1:0] rsp_hit_x,
   input wire logic signed [COORD_W-1:0] rsp_hit_y
);

   // A held response stays until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // An accepted cast makes the core busy in the following cycle.
   a_cast_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd == CMD_CAST |=> !req_ready)
      else $error("request taken during a cast");

   // An out-of-bounds ray carries no hit code.
   a_oob_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_oob |-> rsp_code == '0)
      else $error("hit code on an out-of-bounds ray");

   // A hit is never on an empty cell and lies inside the stored map.
   a_hit_cell: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_oob |-> rsp_code != EMPTY_CODE
         && rsp_hit_x[COORD_W-1:CELL_W] == '0 && rsp_hit_y[COORD_W-1:CELL_W] == '0)
      else $error("hit on an empty or outside cell");

endmodule

bind grid_dda_raycaster_core rdc_checker u_rdc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .req_cmd   (req_ch.cmd),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_oob   (rsp_ch.out_of_bounds),
   .rsp_code  (rsp_ch.hit_code),
   .rsp_hit_x (rsp_ch.hit_x),
   .rsp_hit_y (rsp_ch.hit_y)
);

`default_nettype wire

// ----- tb/tb_grid_dda_raycaster_core.sv -----
// ----------------------------------------------------------------------------
// Grid DDA raycaster core testbench
// Fills a walled corner of the tile map, then casts directed and random rays
// under several map sizes. A scoreboard predicts each response word from its
// own copy of the map and compares it field by field. Both handshake sides
// idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_grid_dda_raycaster_core
   import rdc_pkg::*;
   ;

   localparam int CYCLE_LIMIT = 20000000;
   localparam int SETTLE      = 800;
   // Side of the written corner; its last row and last column are walls, so
   // that no ray ever reaches a cell outside it.
   localparam int REGION      = 32;

   typedef struct packed {
      logic                    cmd;
      logic [CELL_W-1:0]       cell_x;
      logic [CELL_W-1:0]       cell_y;
      logic [CODE_W-1:0]       cell_code;
      logic [POS_W-1:0]        player_x;
      logic [POS_W-1:0]        player_y;
      logic signed [DIR_W-1:0] dir_x;
      logic signed [DIR_W-1:0] dir_y;
   } ray_request_type;

   typedef struct packed {
      logic                oob;
      logic [CODE_W-1:0]   code;
      logic [SIDE_W-1:0]   side;
      logic [DIST_W-1:0]   perp;
      logic [TEX_W-1:0]    tex;
      logic [COORD_W-1:0]  cell_x;
      logic [COORD_W-1:0]  cell_y;
   } ray_result_type;

   // Scoreboard: own copy of the map and sizes, queue of predicted hits.
   class ray_scoreboard;
      logic [CODE_W-1:0] tiles [MAP_DIM*MAP_DIM];
      int                cols = 64;
      int                rows = 64;
      ray_result_type    pending_hits [$];
      int                errors = 0;

      function void set_size(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         if (idx == CSR_MAP_WIDTH) cols = val;
         else if (idx == CSR_MAP_HEIGHT) rows = val;
      endfunction

      function ray_result_type trace_ray(ray_request_type w);
         longint unsigned px, py, ax, ay, nx, ny, n, a, t, q, r, base, unit;
         longint dx, dy, cx, cy, sx, sy, wl, hl, comp;
         bit done, oob, on_x;
         logic [CODE_W-1:0] code, c;
         ray_result_type res;
         px = w.player_x; py = w.player_y;
         dx = longint'(w.dir_x); dy = longint'(w.dir_y);
         ax = dx < 0 ? -dx : dx;
         ay = dy < 0 ? -dy : dy;
         wl = cols > MAP_DIM ? MAP_DIM : cols;
         hl = rows > MAP_DIM ? MAP_DIM : rows;
         unit = 64'd1 << FRAC_BITS;
         cx = px >> FRAC_BITS; cy = py >> FRAC_BITS;
         sx = dx < 0 ? -1 : 1; sy = dy < 0 ? -1 : 1;
         nx = dx < 0 ? px - (cx << FRAC_BITS) : ((cx + 1) << FRAC_BITS) - px;
         ny = dy < 0 ? py - (cy << FRAC_BITS) : ((cy + 1) << FRAC_BITS) - py;
         n = 0; done = 0; oob = 0; on_x = 0; code = 0;
         // Walk cell by cell until a wall or the map edge.
         for (int g = 0; !done && g < STEP_MAX; g++) begin
            if (nx * ay < ny * ax) begin
               n = nx; nx += unit; cx += sx; on_x = 1;
            end else begin
               n = ny; ny += unit; cy += sy; on_x = 0;
            end
            if (cx < 0 || cx >= wl || cy < 0 || cy >= hl) begin
               oob = 1; done = 1;
            end else begin
               c = tiles[cy * MAP_DIM + cx];
               if (c != EMPTY_CODE) begin
                  code = c; done = 1;
               end
            end
         end
         if (!done) oob = 1;
         if (on_x) begin
            a = ax; t = ay; base = py; comp = dy;
         end else begin
            a = ay; t = ax; base = px; comp = dx;
         end
         // Distance and texture fraction of the last boundary crossed.
         if (a == 0) begin
            res.perp = DIST_MAX;
            res.tex = '0;
         end else begin
            q = (n << DIR_FRAC) / a;
            res.perp = q > DIST_MAX ? DIST_MAX : q[DIST_W-1:0];
            t = n * t;
            q = t / a;
            r = t % a;
            if (comp >= 0) base = base + q;
            else base = base - q - (r != 0 ? 1 : 0);
            res.tex = base[TEX_W-1:0];
         end
         if (on_x) res.side = dx < 0 ? SIDE_NEG_X : SIDE_POS_X;
         else res.side = dy < 0 ? SIDE_NEG_Y : SIDE_POS_Y;
         res.oob = oob;
         res.code = oob ? '0 : code;
         res.cell_x = cx[COORD_W-1:0];
         res.cell_y = cy[COORD_W-1:0];
         return res;
      endfunction

      function void note_word(ray_request_type w);
         if (w.cmd == CMD_WRITE) tiles[w.cell_y * MAP_DIM + w.cell_x] = w.cell_code;
         else pending_hits.push_back(trace_ray(w));
      endfunction

      function void check_word(ray_result_type got);
         ray_result_type exp;
         if (pending_hits.size() == 0) begin
            errors++;
            if (errors <= 10) $display("Response word with nothing expected");
            return;
         end
         exp = pending_hits.pop_front();
         if (got !== exp) begin
            errors++;
            if (errors <= 10) begin
               $display("Mismatch: expected oob=%0d code=%0d side=%0d dist=%0d tex=%0d x=%0d y=%0d",
                        exp.oob, exp.code, exp.side, exp.perp, exp.tex,
                        $signed(exp.cell_x), $signed(exp.cell_y));
               $display("          actual   oob=%0d code=%0d side=%0d dist=%0d tex=%0d x=%0d y=%0d",
                        got.oob, got.code, got.side, got.perp, got.tex,
                        $signed(got.cell_x), $signed(got.cell_y));
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycles = 0;
   bit   rsp_calm = 0;
   ray_scoreboard sb = new();

   rdc_req_if req_ch ();
   rdc_rsp_if rsp_ch ();
   rdc_csr_if csr_ch ();

   grid_dda_raycaster_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Cycle limit guards against a hung core.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Note every accepted request word and check every accepted response word.
   always @(posedge clock) begin
      ray_result_type got;
      if (!reset && req_ch.valid && req_ch.ready)
         sb.note_word('{req_ch.cmd, req_ch.cell_x, req_ch.cell_y, req_ch.cell_code,
                        req_ch.player_x, req_ch.player_y, req_ch.dir_x, req_ch.dir_y});
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.out_of_bounds, rsp_ch.hit_code, rsp_ch.side, rsp_ch.distance,
                 rsp_ch.wall_frac, rsp_ch.hit_x, rsp_ch.hit_y};
         sb.check_word(got);
      end
   end

   function automatic int gap_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // A random tile code that is never the empty code.
   function automatic int wall_code();
      int c;
      c = $urandom_range(0, 255);
      return (c == EMPTY_CODE) ? c + 1 : c;
   endfunction

   // Receiver stalls; calm stretches keep ready high throughout.
   always @(posedge clock) begin
      int stall;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (stall > 0) begin
         stall--;
      end else if (!rsp_calm && $urandom_range(0, 3) == 0) begin
         rsp_ch.ready <= 1'b0;
         stall = gap_length();
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   task automatic send_word(ray_request_type w, bit calm);
      int n;
      req_ch.valid <= 1'b1;
      req_ch.cmd <= w.cmd;
      req_ch.cell_x <= w.cell_x;
      req_ch.cell_y <= w.cell_y;
      req_ch.cell_code <= w.cell_code;
      req_ch.player_x <= w.player_x;
      req_ch.player_y <= w.player_y;
      req_ch.dir_x <= w.dir_x;
      req_ch.dir_y <= w.dir_y;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      n = calm ? 0 : gap_length();
      if (n > 0) begin
         req_ch.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic write_tile(int x, int y, int code, bit calm);
      ray_request_type w;
      w = '{CMD_WRITE, CELL_W'(x), CELL_W'(y), CODE_W'(code),
            POS_W'($urandom), POS_W'($urandom), DIR_W'($urandom), DIR_W'($urandom)};
      send_word(w, calm);
   endtask

   task automatic cast_ray(int px, int py, int dx, int dy);
      ray_request_type w;
      w = '{CMD_CAST, CELL_W'($urandom), CELL_W'($urandom), CODE_W'($urandom),
            POS_W'(px), POS_W'(py), DIR_W'(dx), DIR_W'(dy)};
      send_word(w, 0);
   endtask

   // Wait until every response has arrived and the core has settled.
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_hits.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_map_size(int cols, int rows);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= CSR_MAP_WIDTH;
      csr_ch.data <= CSR_DATA_W'(cols);
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      sb.set_size(CSR_MAP_WIDTH, CSR_DATA_W'(cols));
      csr_ch.index <= CSR_MAP_HEIGHT;
      csr_ch.data <= CSR_DATA_W'(rows);
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      sb.set_size(CSR_MAP_HEIGHT, CSR_DATA_W'(rows));
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic int random_dir();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return $signed(16'($urandom));
         2: return $urandom_range(0, 1) ? 16384 : -16384;
         3: return $urandom_range(0, 1) ? $urandom_range(1, 40) : -$urandom_range(1, 40);
         default: return $urandom_range(0, 32768) - 16384;
      endcase
   endfunction

   // Start position on one axis. Starts anywhere in the position range only
   // when the whole used map lies inside the written corner; otherwise the
   // start cell stays inside the walls.
   function automatic int random_pos(int span, bit wide);
      int lim;
      if (wide && $urandom_range(0, 9) == 0) return $urandom_range(0, 4194303);
      lim = span > REGION - 1 ? REGION - 1 : span;
      lim = lim < 1 ? 1 : lim;
      return ($urandom_range(0, lim - 1) << FRAC_BITS) | $urandom_range(0, 65535);
   endfunction

   // Random phase: mostly casts, with tile writes reshaping the inner cells.
   task automatic random_phase(int count);
      bit wide;
      wide = sb.cols <= REGION && sb.rows <= REGION;
      for (int i = 0; i < count; i++) begin
         rsp_calm = (i / 20) % 4 == 3;
         if ($urandom_range(0, 9) < 3)
            write_tile($urandom_range(0, REGION - 2), $urandom_range(0, REGION - 2),
                       $urandom_range(0, 3) != 0 ? EMPTY_CODE : $urandom_range(0, 255), 0);
         else
            cast_ray(random_pos(sb.cols, wide), random_pos(sb.rows, wide),
                     random_dir(), random_dir());
      end
      rsp_calm = 0;
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.cmd = CMD_WRITE;
      req_ch.cell_x = '0;
      req_ch.cell_y = '0;
      req_ch.cell_code = '0;
      req_ch.player_x = '0;
      req_ch.player_y = '0;
      req_ch.dir_x = '0;
      req_ch.dir_y = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_MAP_WIDTH;
      csr_ch.data = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill the corner, walled on its far row and column, so that no ray
      // reads an unwritten cell.
      for (int y = 0; y < REGION; y++) begin
         for (int x = 0; x < REGION; x++) begin
            if (x == REGION - 1 || y == REGION - 1)
               write_tile(x, y, wall_code(), $urandom_range(0, 3) != 0);
            else
               write_tile(x, y,
                          $urandom_range(0, 9) != 0 ? EMPTY_CODE : $urandom_range(0, 255),
                          $urandom_range(0, 3) != 0);
         end
      end

      // Directed rays: code extremes, zero components, direction and position extremes.
      write_tile(5, 3, 0, 0);
      write_tile(3, 5, 255, 0);
      write_tile(3, 3, EMPTY_CODE, 0);
      cast_ray(3 << 16 | 16'h8000, 3 << 16 | 16'h8000, 16384, 0);
      cast_ray(3 << 16 | 16'h8000, 3 << 16 | 16'h8000, 0, 16384);
      cast_ray(3 << 16 | 16'h8000, 3 << 16 | 16'h8000, 0, 0);
      cast_ray(3 << 16, 3 << 16, -16384, -16384);
      cast_ray(0, 0, -32768, 32767);
      cast_ray(4194303, 4194303, 32767, -32768);
      cast_ray(4194303, 0, 1, -1);
      cast_ray(0, 4194303, -1, 0);
      cast_ray(3 << 16 | 16'h0001, 3 << 16 | 16'hFFFF, 11585, 11585);
      cast_ray(20 << 16, 20 << 16, 0, -16384);
      cast_ray(20 << 16, 20 << 16, 16384, 16384);
      drain();

      // Several map sizes, the extremes among them.
      set_map_size(64, 64);
      random_phase(150);
      drain();
      set_map_size(1, 1);
      cast_ray(0, 0, 16384, 0);
      cast_ray(5 << 16, 9 << 16, -100, 300);
      random_phase(50);
      drain();
      set_map_size(127, 127);
      random_phase(100);
      drain();
      set_map_size(0, 0);
      random_phase(40);
      drain();
      set_map_size($urandom_range(2, 63), $urandom_range(2, 63));
      random_phase(100);
      drain();
      set_map_size(64, $urandom_range(65, 127));
      random_phase(60);
      drain();

      if (sb.errors == 0 && sb.pending_hits.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
